@@ src/trle_pkg.sv @@
// ---------------------------------------------------------------------------
// trle_pkg
// Shared types and constants for the threshold run-length encoder.
// ---------------------------------------------------------------------------
package trle_pkg;

  localparam int SYM_W = 8;
  localparam int LEN_W = 16;
  localparam int MIN_W = 4;
  localparam int DIGIT_W = 4;
  localparam int NUM_DIGITS = 5;            // 65535 has five decimal digits
  localparam int DIG_CNT_W = 3;

  localparam logic [LEN_W-1:0] MAX_RUN = 16'hFFFF;
  localparam logic [MIN_W-1:0] MIN_RUN_RESET = 4'd5;
  localparam logic [MIN_W-1:0] MIN_RUN_FLOOR = 4'd2;
  localparam logic [MIN_W-1:0] MIN_RUN_CEIL = 4'd8;

  localparam logic [SYM_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] ASCII_OPEN = 8'h28;
  localparam logic [SYM_W-1:0] ASCII_CLOSE = 8'h29;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [16:0] DIV10_MUL = 17'd52429;
  localparam int DIV10_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;           // power of two, pointers wrap
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // one run to be written out
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    logic             last;   // closes the burst of its input beat
    logic             eot;    // closes the whole encoded text
  } trle_cmd_t;

endpackage

@@ src/trle_front.sv @@
// ---------------------------------------------------------------------------
// trle_front
// Tracks the open run and turns each input beat into zero, one or two
// run commands for the writer.
// ---------------------------------------------------------------------------
module trle_front import trle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] symbol,
  input  logic             end_of_text,
  output logic             push_valid,
  input  logic             push_ready,
  output trle_cmd_t        push_data
);

  logic [SYM_W-1:0] run_symbol;
  logic [LEN_W-1:0] run_length;
  logic             run_open;
  trle_cmd_t        slot;
  logic             slot_valid;
  logic             slot_valid_next;
  trle_cmd_t        pend;
  logic             pend_valid;

  logic             extend;
  logic             slot_free;
  logic             accept;
  logic             have1;
  logic             have2;
  trle_cmd_t        c1;
  trle_cmd_t        c2;
  trle_cmd_t        single;

  assign extend    = run_open && (symbol == run_symbol) && (run_length != MAX_RUN);
  assign slot_free = !slot_valid || push_ready;
  assign in_ready  = slot_free && !pend_valid;
  assign accept    = in_valid && in_ready;

  assign push_valid = slot_valid;
  assign push_data  = slot;

  always_comb begin
    single = '{sym: symbol, len: LEN_W'(1), last: 1'b1, eot: 1'b1};
    have1  = 1'b0;
    have2  = 1'b0;
    c1     = single;
    c2     = single;
    if (extend) begin
      have1 = end_of_text;
      c1    = '{sym: run_symbol, len: run_length + LEN_W'(1), last: 1'b1, eot: 1'b1};
    end else if (run_open) begin
      have1 = 1'b1;
      have2 = end_of_text;
      c1    = '{sym: run_symbol, len: run_length, last: !end_of_text, eot: 1'b0};
    end else begin
      have1 = end_of_text;
    end
  end

  always_comb begin
    slot_valid_next = slot_valid && !push_ready;
    if ((pend_valid && slot_free) || (accept && have1)) begin
      slot_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol <= '0;
      run_length <= '0;
      run_open   <= 1'b0;
      slot_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      slot_valid <= slot_valid_next;
      if (pend_valid && slot_free) begin
        slot       <= pend;
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (end_of_text) begin
          run_symbol <= '0;
          run_length <= '0;
          run_open   <= 1'b0;
        end else if (extend) begin
          run_length <= run_length + LEN_W'(1);
        end else begin
          run_symbol <= symbol;
          run_length <= LEN_W'(1);
          run_open   <= 1'b1;
        end
        if (have1) begin
          slot <= c1;
        end
        if (have2) begin
          pend       <= c2;
          pend_valid <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/trle_queue.sv @@
// ---------------------------------------------------------------------------
// trle_queue
// Short command queue between the run tracker and the writer.
// ---------------------------------------------------------------------------
module trle_queue import trle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  trle_cmd_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output trle_cmd_t pop_data
);

  trle_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/trle_back.sv @@
// ---------------------------------------------------------------------------
// trle_back
// Writes one run command as output bytes: plain copies, or byte '(' digits
// ')' with the decimal digits produced one per cycle.
// ---------------------------------------------------------------------------
module trle_back import trle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [MIN_W-1:0] min_run,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  trle_cmd_t        pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_byte,
  output logic             end_of_burst,
  output logic             end_of_output
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SYM   = 3'd2;
  localparam logic [2:0] S_OPEN  = 3'd3;
  localparam logic [2:0] S_DIG   = 3'd4;
  localparam logic [2:0] S_CLOSE = 3'd5;
  localparam logic [2:0] S_PLAIN = 3'd6;

  logic [2:0]           state;
  trle_cmd_t            cmd;
  logic [LEN_W-1:0]     val;
  logic [DIG_CNT_W-1:0] ndig;
  logic [2:0]           cnt;
  logic [DIGIT_W-1:0]   digits [NUM_DIGITS];

  logic [MIN_W-1:0]     min_eff;
  logic                 can_load;
  logic                 load_beat;
  logic [32:0]          prod;
  logic [LEN_W-1:0]     quot;
  logic [LEN_W-1:0]     quot10;
  logic [LEN_W-1:0]     diff;
  logic [DIGIT_W-1:0]   rem;

  always_comb begin
    min_eff = min_run;
    if (min_run < MIN_RUN_FLOOR) begin
      min_eff = MIN_RUN_FLOOR;
    end else if (min_run > MIN_RUN_CEIL) begin
      min_eff = MIN_RUN_CEIL;
    end
  end

  // divide by ten through the reciprocal, remainder by back-multiply
  assign prod   = val * DIV10_MUL;
  assign quot   = LEN_W'(prod[32:DIV10_SHIFT]);
  assign quot10 = (quot << 3) + (quot << 1);
  assign diff   = val - quot10;
  assign rem    = diff[DIGIT_W-1:0];

  assign can_load  = !out_valid || out_ready;
  assign load_beat = can_load && (state inside {S_SYM, S_OPEN, S_DIG, S_CLOSE, S_PLAIN});
  assign pop_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_beat || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cmd <= pop_data;
            if (pop_data.len >= LEN_W'(min_eff)) begin
              val   <= pop_data.len;
              ndig  <= '0;
              state <= S_CONV;
            end else begin
              cnt   <= pop_data.len[2:0];   // below min, so at most seven
              state <= S_PLAIN;
            end
          end
        end
        S_CONV: begin
          digits[ndig] <= rem;
          ndig         <= ndig + DIG_CNT_W'(1);
          val          <= quot;
          if (quot == '0) begin
            state <= S_SYM;
          end
        end
        S_SYM: begin
          if (can_load) begin
            out_byte      <= cmd.sym;
            end_of_burst  <= 1'b0;
            end_of_output <= 1'b0;
            state         <= S_OPEN;
          end
        end
        S_OPEN: begin
          if (can_load) begin
            out_byte      <= ASCII_OPEN;
            end_of_burst  <= 1'b0;
            end_of_output <= 1'b0;
            state         <= S_DIG;
          end
        end
        S_DIG: begin
          if (can_load) begin
            out_byte      <= ASCII_ZERO + SYM_W'(digits[ndig - DIG_CNT_W'(1)]);
            end_of_burst  <= 1'b0;
            end_of_output <= 1'b0;
            ndig          <= ndig - DIG_CNT_W'(1);
            if (ndig == DIG_CNT_W'(1)) begin
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          if (can_load) begin
            out_byte      <= ASCII_CLOSE;
            end_of_burst  <= cmd.last;
            end_of_output <= cmd.eot;
            state         <= S_IDLE;
          end
        end
        S_PLAIN: begin
          if (can_load) begin
            out_byte      <= cmd.sym;
            end_of_burst  <= cmd.last && (cnt == 3'd1);
            end_of_output <= cmd.eot && (cnt == 3'd1);
            cnt           <= cnt - 3'd1;
            if (cnt == 3'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/threshold_run_length_encoder.sv @@
// ---------------------------------------------------------------------------
// threshold_run_length_encoder
// Run-length encoder for byte text with a minimum run for compressed form.
// ---------------------------------------------------------------------------
// Input beats (symbol, end_of_text) enter on in_valid/in_ready. Equal
// neighboring bytes form a run of up to 65535 bytes. A run that closes is
// written on out_valid/out_ready either as byte '(' count ')' when it is at
// least min_run long (values below 2 act as 2, above 8 as 8), or as plain
// copies otherwise. end_of_burst marks the last byte caused by one input
// beat, end_of_output the last byte of the text.
// The run tracker takes a beat per cycle while it has room for the up to two
// run commands a beat can produce; a two-entry queue feeds the writer.
// The writer loads each run command in its idle state, then writes the plain
// bytes, or converts the count into d digits (one divide-by-ten per cycle)
// and writes d + 3 output beats. With queue and writer empty, the command of
// a closing beat passes the tracker's slot, the queue, the writer's idle state
// and, for a compressed run, the conversion before its first byte is output.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops. Reset clears the open run, the queue and the output, and
// sets min_run to 5. min_run is written via cfg_valid/cfg_data, ready always;
// the block leaves it to the user to write it only while the encoder is idle.
// ---------------------------------------------------------------------------
module threshold_run_length_encoder import trle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MIN_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] symbol,
  input  logic             end_of_text,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_byte,
  output logic             end_of_burst,
  output logic             end_of_output
);

  logic [MIN_W-1:0] min_run;
  logic             push_valid;
  logic             push_ready;
  trle_cmd_t        push_data;
  logic             pop_valid;
  logic             pop_ready;
  trle_cmd_t        pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run <= MIN_RUN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_run <= cfg_data;
    end
  end

  trle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .symbol      (symbol),
    .end_of_text (end_of_text),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  trle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  trle_back u_back (
    .clk           (clk),
    .rst           (rst),
    .min_run       (min_run),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .end_of_burst  (end_of_burst),
    .end_of_output (end_of_output)
  );

endmodule

@@ src/trle_checker.sv @@
// ---------------------------------------------------------------------------
// trle_checker
// Port-level checks for the threshold run-length encoder.
// ---------------------------------------------------------------------------
module trle_checker import trle_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cfg_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SYM_W-1:0] out_byte,
  input logic             end_of_burst,
  input logic             end_of_output
);

  // nothing leaves the encoder right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat right after reset");

  // the end of the text is always the end of a burst
  a_eoo_in_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_output |-> end_of_burst)
    else $error("end_of_output without end_of_burst");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(end_of_burst) && $stable(end_of_output))
    else $error("stalled output beat changed");

  // config port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind threshold_run_length_encoder trle_checker u_trle_checker (.*);

@@ bench/threshold_run_length_encoder_test.sv @@
// ---------------------------------------------------------------------------
// threshold_run_length_encoder_test
// Self-checking bench for the threshold run-length encoder. Text beats go in
// on the valid/ready input with random gaps, and encoded bytes come back
// under random receiver stalls. Every accepted input beat is run through a
// local copy of the encoder: the open run, its length, and min_run. The
// bytes it predicts are queued and compared field by field with each output
// beat. Directed texts cover byte extremes, the min_run clamps and
// multi-digit counts. Random texts follow under several min_run settings,
// with a long receiver hold-off and sender pauses in between.
// ---------------------------------------------------------------------------
module threshold_run_length_encoder_test;
  import trle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_SETTLE = 30;     // writer idle + digit conversion slack
  localparam int PHASE_ITEMS = 20;
  localparam int NUM_PHASES = 3;

  typedef struct {
    logic [SYM_W-1:0] b;
    logic             eob;
    logic             eoo;
  } enc_byte_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [MIN_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [SYM_W-1:0] symbol;
  logic             end_of_text;
  logic             out_valid;
  logic             out_ready;
  logic [SYM_W-1:0] out_byte;
  logic             end_of_burst;
  logic             end_of_output;

  // encoder copy
  logic [MIN_W-1:0] min_run_q;
  logic [SYM_W-1:0] run_sym;
  logic [LEN_W-1:0] run_len;
  logic             run_open;

  enc_byte_t expected_bytes[$];
  enc_byte_t step_bytes[$];
  int        mismatch_count = 0;
  int        out_count = 0;
  bit        tx_idle_en = 1'b0;
  bit        rx_idle_en = 1'b0;
  int        hold_left = 0;

  threshold_run_length_encoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .symbol       (symbol),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .end_of_burst (end_of_burst),
    .end_of_output(end_of_output)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- prediction ----------------

  function automatic logic [MIN_W-1:0] min_run_used();
    if (min_run_q < MIN_RUN_FLOOR) return MIN_RUN_FLOOR;
    if (min_run_q > MIN_RUN_CEIL) return MIN_RUN_CEIL;
    return min_run_q;
  endfunction

  function automatic void add_byte(input logic [SYM_W-1:0] b);
    enc_byte_t e;
    e.b = b;
    e.eob = 1'b0;
    e.eoo = 1'b0;
    step_bytes.push_back(e);
  endfunction

  function automatic void push_run(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len);
    logic [SYM_W-1:0] digits[$];
    logic [SYM_W-1:0] digit;
    int unsigned      v;
    if (len >= LEN_W'(min_run_used())) begin
      add_byte(sym);
      add_byte(ASCII_OPEN);
      v = 32'(len);
      do begin
        digit = ASCII_ZERO + SYM_W'(v % 10);
        digits.push_front(digit);
        v = v / 10;
      end while (v != 0);
      foreach (digits[i]) add_byte(digits[i]);
      add_byte(ASCII_CLOSE);
    end else begin
      for (int i = 0; i < len; i++) add_byte(sym);
    end
  endfunction

  function automatic void encode_symbol(input logic [SYM_W-1:0] sym, input logic eot);
    enc_byte_t last;
    step_bytes.delete();
    if (run_open && sym == run_sym && run_len < MAX_RUN) begin
      run_len = run_len + 1'b1;
    end else begin
      if (run_open) push_run(run_sym, run_len);
      run_sym = sym;
      run_len = LEN_W'(1);
      run_open = 1'b1;
    end
    if (eot) begin
      push_run(run_sym, run_len);
      run_sym = '0;
      run_len = '0;
      run_open = 1'b0;
    end
    if (step_bytes.size() > 0) begin
      last = step_bytes.pop_back();
      last.eob = 1'b1;
      last.eoo = eot;
      step_bytes.push_back(last);
    end
    foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_output
    enc_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("beat %0d: byte %02h with nothing expected",
                                  out_count, out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.b)
          report_mismatch($sformatf("beat %0d: out_byte %02h, want %02h",
                                    out_count, out_byte, want.b));
        if (end_of_burst !== want.eob)
          report_mismatch($sformatf("beat %0d: end_of_burst %b, want %b",
                                    out_count, end_of_burst, want.eob));
        if (end_of_output !== want.eoo)
          report_mismatch($sformatf("beat %0d: end_of_output %b, want %b",
                                    out_count, end_of_output, want.eoo));
      end
      out_count++;
    end
  end

  // receiver: random stall bursts, plus a long hold-off when asked
  initial begin : receiver
    int gap_left;
    gap_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        gap_left = $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- driving ----------------
  // All driving tasks start and end at a falling edge.

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic eot);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    symbol <= sym;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    encode_symbol(sym, eot);
    @(negedge clk);
  endtask

  task automatic send_run(input logic [SYM_W-1:0] sym, input int len, input logic eot);
    for (int i = 0; i < len; i++) send_symbol(sym, eot && (i == len - 1));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_SETTLE) @(negedge clk);
  endtask

  // only called once drained, with no run open
  task automatic write_min_run(input logic [MIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    min_run_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------- tests ----------------

  task automatic test_basic_texts();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_symbol(8'h61, 1'b1);          // one-byte text
    send_run(8'h00, 4, 1'b0);          // short run, plain
    send_run(8'hFF, 5, 1'b1);          // run at the minimum
    send_run(8'h62, 5, 1'b0);
    send_symbol(8'h63, 1'b1);          // final byte opens a new run
    send_run(8'h64, 10, 1'b1);         // two-digit count
    wait_drained();
  endtask

  task automatic test_min_clamps();
    write_min_run(4'd0);               // acts as 2
    send_run(8'h78, 2, 1'b0);
    send_symbol(8'h79, 1'b1);
    wait_drained();
    write_min_run(4'd1);
    send_run(8'h70, 2, 1'b1);
    send_symbol(8'h71, 1'b1);
    wait_drained();
    write_min_run(4'd15);              // acts as 8
    send_run(8'h6D, 8, 1'b1);
    send_run(8'h6E, 7, 1'b0);
    send_symbol(8'h6F, 1'b1);
    wait_drained();
    write_min_run(4'd8);
    send_run(8'h6B, 8, 1'b0);
    send_run(8'h6C, 7, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_counts();
    write_min_run(4'd2);
    tx_idle_en = 1'b0;
    send_run(8'h41, 9, 1'b0);
    send_run(8'h42, 10, 1'b0);
    send_run(8'h43, 100, 1'b1);        // three-digit count
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_left = 300;
    for (int i = 0; i < 20; i++) send_run(SYM_W'(8'h30 + i), 2, 1'b0);
    wait_drained();                    // sender pause with the text still open
    for (int i = 0; i < 10; i++) send_symbol(SYM_W'(8'hC0 + i), i == 9);
    wait_drained();
  endtask

  task automatic test_random_texts();
    int               sent;
    int               text_len;
    int               pos;
    int               len;
    bit               noisy;
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] sym;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_min_run(MIN_W'($urandom_range(0, 15)));
      tx_idle_en = (p == 0);
      rx_idle_en = (p < NUM_PHASES - 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        text_len = $urandom_range(1, 24);
        noisy = ($urandom_range(0, 3) == 0);
        base = SYM_W'($urandom_range(0, 255));
        pos = 0;
        while (pos < text_len) begin
          if (noisy) begin
            sym = SYM_W'($urandom_range(0, 255));
            len = 1;
          end else begin
            sym = base + SYM_W'($urandom_range(0, 2));
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
          end
          if (len > text_len - pos) len = text_len - pos;
          send_run(sym, len, pos + len == text_len);
          pos += len;
          if (p < NUM_PHASES - 1 && $urandom_range(0, 29) == 0) wait_drained();
        end
        sent += text_len;
      end
      wait_drained();
    end
  endtask

  // ---------------- sequence ----------------

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    symbol = '0;
    end_of_text = 1'b0;
    min_run_q = MIN_RUN_RESET;
    run_sym = '0;
    run_len = '0;
    run_open = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_texts();
    test_min_clamps();
    test_long_counts();
    test_backpressure();
    test_random_texts();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
